FILE: design/escape_key_decoder_with_cursor_core_assert.svh
// Assertion macros for the escape key decoder RTL.
`ifndef ESCAPE_KEY_DECODER_WITH_CURSOR_CORE_ASSERT_SVH
`define ESCAPE_KEY_DECODER_WITH_CURSOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while reset is released.
`define EKD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define EKD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EKD_ASSERT(lbl, clk, rst_n, prop, msg)
`define EKD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: design/ekd_pkg.sv
// Types, codes and decode tables of the escape key decoder.
`timescale 1ns / 1ps
`default_nettype none
package ekd_pkg;

    localparam int unsigned COORD_W = 12;

    // Key kinds as they appear on the result word.
    localparam logic [3:0] K_PLAIN = 4'd0;
    localparam logic [3:0] K_ESC   = 4'd1;
    localparam logic [3:0] K_UP    = 4'd2;
    localparam logic [3:0] K_DOWN  = 4'd3;
    localparam logic [3:0] K_RIGHT = 4'd4;
    localparam logic [3:0] K_LEFT  = 4'd5;
    localparam logic [3:0] K_HOME  = 4'd6;
    localparam logic [3:0] K_END   = 4'd7;
    localparam logic [3:0] K_DEL   = 4'd8;
    localparam logic [3:0] K_PGUP  = 4'd9;
    localparam logic [3:0] K_PGDN  = 4'd10;

    localparam logic [7:0] BYTE_ESC     = 8'h1B;
    localparam logic [7:0] BYTE_BRACKET = 8'h5B;
    localparam logic [7:0] BYTE_SS3     = 8'h4F;
    localparam logic [7:0] BYTE_TILDE   = 8'h7E;
    localparam logic [7:0] BYTE_ZERO    = 8'h30;
    localparam logic [7:0] BYTE_NINE    = 8'h39;
    localparam logic [7:0] BYTE_H       = 8'h48;
    localparam logic [7:0] BYTE_F       = 8'h46;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;
    localparam logic [7:0] QUIT_BYTE    = 8'h71 & CTRL_MASK;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic REG_SCREEN_ROWS = 1'b0;
    localparam logic REG_SCREEN_COLS = 1'b1;

    localparam logic [COORD_W-1:0] ROWS_RESET = 12'd24;
    localparam logic [COORD_W-1:0] COLS_RESET = 12'd80;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         key_kind;
        logic [7:0]         key_char;
        logic [COORD_W-1:0] cursor_col;
        logic [COORD_W-1:0] cursor_row;
        logic               quit;
    } t_out_word;

    // Decoded key handed from the decoder to the cursor stage.
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
    } t_key_evt;

    function automatic logic [3:0] after_bracket(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            8'h41:   k = K_UP;
            8'h42:   k = K_DOWN;
            8'h43:   k = K_RIGHT;
            8'h44:   k = K_LEFT;
            BYTE_H:  k = K_HOME;
            BYTE_F:  k = K_END;
            default: k = K_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] digit_key(input logic [7:0] d);
        logic [3:0] k;
        unique case (d)
            8'h31:   k = K_HOME;
            8'h33:   k = K_DEL;
            8'h34:   k = K_END;
            8'h35:   k = K_PGUP;
            8'h36:   k = K_PGDN;
            8'h37:   k = K_HOME;
            8'h38:   k = K_END;
            default: k = K_ESC;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: design/escape_key_decoder_with_cursor_core.sv
// Top level of the escape key decoder with screen cursor.
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_word (action, rx_byte)
//  result   out        o_valid / i_stall   o_word (key, char, col, row, quit)
//  config   in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One word is taken per cycle while the key queue is not full; a result passes
// the decoder, the queue register and the output register. Escape bytes and sequence bytes
// that complete nothing give no result. Reset is synchronous and empties the
// queue and the output register. The input stalls only when the key queue is
// full, which happens when the result side has stalled for a while.
`timescale 1ns / 1ps
`default_nettype none
`include "escape_key_decoder_with_cursor_core_assert.svh"
module escape_key_decoder_with_cursor_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    input  ekd_pkg::t_in_word          i_word,
    output logic                       o_stall,
    output logic                       o_valid,
    output ekd_pkg::t_out_word         o_word,
    input  wire                        i_stall,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire [ekd_pkg::COORD_W-1:0] i_cfg_data
);

    logic [ekd_pkg::COORD_W-1:0] r_screen_rows;
    logic [ekd_pkg::COORD_W-1:0] r_screen_cols;
    logic              q_full;
    logic              evt_push;
    ekd_pkg::t_key_evt evt_in;
    logic              q_valid;
    logic              q_pop;
    ekd_pkg::t_key_evt evt_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_rows <= ekd_pkg::ROWS_RESET;
            r_screen_cols <= ekd_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ekd_pkg::REG_SCREEN_ROWS: r_screen_rows <= i_cfg_data;
                ekd_pkg::REG_SCREEN_COLS: r_screen_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ekd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_word      (i_word),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_evt_valid (evt_push),
        .o_evt       (evt_in)
    );

    ekd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_push),
        .i_evt   (evt_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_evt   (evt_out)
    );

    ekd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_screen_rows (r_screen_rows),
        .i_screen_cols (r_screen_cols),
        .i_q_valid     (q_valid),
        .i_evt         (evt_out),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_word        (o_word),
        .i_stall       (i_stall)
    );

    `EKD_ASSERT(a_quit_plain, i_clk, i_rst_n, o_valid && o_word.quit |-> o_word.key_kind == ekd_pkg::K_PLAIN && o_word.key_char == ekd_pkg::QUIT_BYTE, "quit on a key that is not Ctrl-Q")
    `EKD_ASSERT(a_char_zero, i_clk, i_rst_n, o_valid && o_word.key_kind != ekd_pkg::K_PLAIN |-> o_word.key_char == 8'd0, "key char set on a non-plain key")
    `EKD_ASSERT(a_kind_range, i_clk, i_rst_n, o_valid |-> o_word.key_kind <= ekd_pkg::K_PGDN, "key kind out of range")
    `EKD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "result or stall after reset")

endmodule
`default_nettype wire

FILE: design/ekd_front.sv
// Byte decoder: tracks escape sequences and emits decoded keys into the queue.
`timescale 1ns / 1ps
`default_nettype none
module ekd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  ekd_pkg::t_in_word i_word,
    output logic              o_stall,
    input  wire               i_q_full,
    output logic              o_evt_valid,
    output ekd_pkg::t_key_evt o_evt
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ESC   = 4'b0010,
        ST_SEQ0  = 4'b0100,
        ST_DIGIT = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic [7:0] r_digit, n_digit;
    logic       accept;
    logic       has_key;
    logic [3:0] kind;
    logic [7:0] ch;
    logic [7:0] b;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign b       = i_word.rx_byte;

    always_comb begin
        n_phase = r_phase;
        n_first = r_first;
        n_digit = r_digit;
        has_key = 1'b0;
        kind    = ekd_pkg::K_ESC;
        ch      = 8'd0;
        if (i_word.action == ekd_pkg::ACT_TICK) begin
            // A timeout inside a sequence gives up on it.
            has_key = (r_phase == ST_ESC) || (r_phase == ST_SEQ0) || (r_phase == ST_DIGIT);
            n_phase = ST_IDLE;
        end else begin
            unique case (r_phase)
                ST_ESC: begin
                    n_first = b;
                    n_phase = ST_SEQ0;
                end
                ST_SEQ0: begin
                    n_phase = ST_IDLE;
                    has_key = 1'b1;
                    if (r_first == ekd_pkg::BYTE_BRACKET) begin
                        if (b >= ekd_pkg::BYTE_ZERO && b <= ekd_pkg::BYTE_NINE) begin
                            n_digit = b;
                            n_phase = ST_DIGIT;
                            has_key = 1'b0;
                        end else begin
                            kind = ekd_pkg::after_bracket(b);
                        end
                    end else if (r_first == ekd_pkg::BYTE_SS3 && b == ekd_pkg::BYTE_H) begin
                        kind = ekd_pkg::K_HOME;
                    end else if (r_first == ekd_pkg::BYTE_SS3 && b == ekd_pkg::BYTE_F) begin
                        kind = ekd_pkg::K_END;
                    end
                end
                ST_DIGIT: begin
                    n_phase = ST_IDLE;
                    has_key = 1'b1;
                    if (b == ekd_pkg::BYTE_TILDE) begin
                        kind = ekd_pkg::digit_key(r_digit);
                    end
                end
                default: begin
                    // Idle, and any code that is not a valid phase.
                    if (b == ekd_pkg::BYTE_ESC) begin
                        n_phase = ST_ESC;
                    end else begin
                        n_phase = ST_IDLE;
                        has_key = 1'b1;
                        kind    = ekd_pkg::K_PLAIN;
                        ch      = b;
                    end
                end
            endcase
        end
    end

    assign o_evt_valid = accept && has_key;
    assign o_evt.kind  = kind;
    assign o_evt.ch    = ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_first <= 8'd0;
            r_digit <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_digit <= n_digit;
        end
    end

endmodule
`default_nettype wire

FILE: design/ekd_queue.sv
// Short register queue of decoded keys between decoder and cursor stage.
`timescale 1ns / 1ps
`default_nettype none
module ekd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  ekd_pkg::t_key_evt i_evt,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_valid,
    output ekd_pkg::t_key_evt o_evt
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    ekd_pkg::t_key_evt r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/ekd_back.sv
// Cursor stage: applies each decoded key to the cursor and holds the result word.
`timescale 1ns / 1ps
`default_nettype none
module ekd_back (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire [ekd_pkg::COORD_W-1:0]        i_screen_rows,
    input  wire [ekd_pkg::COORD_W-1:0]        i_screen_cols,
    input  wire                               i_q_valid,
    input  ekd_pkg::t_key_evt                 i_evt,
    output logic                              o_pop,
    output logic                              o_valid,
    output ekd_pkg::t_out_word                o_word,
    input  wire                               i_stall
);

    localparam int unsigned W = ekd_pkg::COORD_W;

    logic [W-1:0] r_col, n_col;
    logic [W-1:0] r_row, n_row;
    logic         r_out_valid;
    ekd_pkg::t_out_word r_out;
    logic [W-1:0] col_last, row_last;
    logic [W:0]   col_inc, row_inc;
    logic [W-1:0] col_dec, row_dec;

    // A screen size of zero behaves as one.
    assign col_last = (i_screen_cols == '0) ? '0 : i_screen_cols - W'(1);
    assign row_last = (i_screen_rows == '0) ? '0 : i_screen_rows - W'(1);
    assign col_inc  = {1'b0, r_col} + (W+1)'(1);
    assign row_inc  = {1'b0, r_row} + (W+1)'(1);
    assign col_dec  = (r_col == '0) ? '0 : r_col - W'(1);
    assign row_dec  = (r_row == '0) ? '0 : r_row - W'(1);

    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        unique case (i_evt.kind)
            ekd_pkg::K_LEFT:  n_col = (col_dec > col_last) ? col_last : col_dec;
            ekd_pkg::K_RIGHT: n_col = (col_inc > {1'b0, col_last}) ? col_last : col_inc[W-1:0];
            ekd_pkg::K_UP:    n_row = (row_dec > row_last) ? row_last : row_dec;
            ekd_pkg::K_DOWN:  n_row = (row_inc > {1'b0, row_last}) ? row_last : row_inc[W-1:0];
            ekd_pkg::K_HOME:  n_col = '0;
            ekd_pkg::K_END:   n_col = col_last;
            ekd_pkg::K_PGUP:  n_row = '0;
            ekd_pkg::K_PGDN:  n_row = row_last;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_col       <= n_col;
                r_row       <= n_row;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.key_kind   <= i_evt.kind;
            r_out.key_char   <= i_evt.ch;
            r_out.cursor_col <= n_col;
            r_out.cursor_row <= n_row;
            r_out.quit       <= (i_evt.kind == ekd_pkg::K_PLAIN) &&
                                (i_evt.ch == ekd_pkg::QUIT_BYTE);
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
`default_nettype wire

FILE: verif/escape_key_decoder_with_cursor_checker.sv
// Checker that predicts decoded keys and cursor positions and compares them with the block.
`timescale 1ns / 1ps
module escape_key_decoder_with_cursor_checker
    import ekd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_word,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [COORD_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam logic [7:0] BYTE_A = 8'h41;
    localparam logic [7:0] BYTE_B = 8'h42;
    localparam logic [7:0] BYTE_C = 8'h43;
    localparam logic [7:0] BYTE_D = 8'h44;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC_SEEN,
        PH_SEQ_BYTE,
        PH_DIGIT_SEEN
    } t_phase;

    t_phase             phase;
    logic [7:0]         seq_byte;
    logic [7:0]         digit_byte;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [COORD_W-1:0] rows_cfg;
    logic [COORD_W-1:0] cols_cfg;
    t_out_word          expected_keys[$];
    int                 fails = 0;

    assign o_fail_count = fails;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W:0] v,
                                                       input logic [COORD_W-1:0] lim);
        return (v > {1'b0, lim}) ? lim : v[COORD_W-1:0];
    endfunction

    function automatic logic [3:0] bracket_kind(input logic [7:0] b);
        case (b)
            BYTE_A:  return K_UP;
            BYTE_B:  return K_DOWN;
            BYTE_C:  return K_RIGHT;
            BYTE_D:  return K_LEFT;
            BYTE_H:  return K_HOME;
            BYTE_F:  return K_END;
            default: return K_ESC;
        endcase
    endfunction

    function automatic logic [3:0] tilde_kind(input logic [7:0] d);
        case (d)
            BYTE_ZERO + 8'd1, BYTE_ZERO + 8'd7: return K_HOME;
            BYTE_ZERO + 8'd3:                   return K_DEL;
            BYTE_ZERO + 8'd4, BYTE_ZERO + 8'd8: return K_END;
            BYTE_ZERO + 8'd5:                   return K_PGUP;
            BYTE_ZERO + 8'd6:                   return K_PGDN;
            default:                            return K_ESC;
        endcase
    endfunction

    // Advances the decoder by one word and, when a key completes, moves the cursor.
    task automatic decode_key(input t_in_word w, output logic has_key, output t_out_word key);
        logic [3:0]         kind;
        logic [7:0]         ch;
        logic [COORD_W-1:0] col_lim;
        logic [COORD_W-1:0] row_lim;
        has_key = 1'b0;
        kind = K_ESC;
        ch = 8'h00;
        col_lim = (cols_cfg == 0) ? '0 : cols_cfg - 1'b1;
        row_lim = (rows_cfg == 0) ? '0 : rows_cfg - 1'b1;
        if (w.action == ACT_TICK) begin
            has_key = (phase != PH_IDLE);
            phase = PH_IDLE;
        end else begin
            case (phase)
                PH_IDLE: begin
                    if (w.rx_byte == BYTE_ESC) begin
                        phase = PH_ESC_SEEN;
                    end else begin
                        has_key = 1'b1;
                        kind = K_PLAIN;
                        ch = w.rx_byte;
                    end
                end
                PH_ESC_SEEN: begin
                    seq_byte = w.rx_byte;
                    phase = PH_SEQ_BYTE;
                end
                PH_SEQ_BYTE: begin
                    phase = PH_IDLE;
                    has_key = 1'b1;
                    if (seq_byte == BYTE_BRACKET) begin
                        if (w.rx_byte >= BYTE_ZERO && w.rx_byte <= BYTE_NINE) begin
                            digit_byte = w.rx_byte;
                            phase = PH_DIGIT_SEEN;
                            has_key = 1'b0;
                        end else begin
                            kind = bracket_kind(w.rx_byte);
                        end
                    end else if (seq_byte == BYTE_SS3 && w.rx_byte == BYTE_H) begin
                        kind = K_HOME;
                    end else if (seq_byte == BYTE_SS3 && w.rx_byte == BYTE_F) begin
                        kind = K_END;
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    has_key = 1'b1;
                    kind = (w.rx_byte == BYTE_TILDE) ? tilde_kind(digit_byte) : K_ESC;
                end
            endcase
        end
        if (has_key) begin
            // Each moving key clamps only its own axis, so a cursor left beyond a
            // shrunken screen stays there on the other axis.
            case (kind)
                K_LEFT:  col_pos = clamp_coord((col_pos == 0) ? '0 : col_pos - 1'b1, col_lim);
                K_RIGHT: col_pos = clamp_coord({1'b0, col_pos} + 1'b1, col_lim);
                K_UP:    row_pos = clamp_coord((row_pos == 0) ? '0 : row_pos - 1'b1, row_lim);
                K_DOWN:  row_pos = clamp_coord({1'b0, row_pos} + 1'b1, row_lim);
                K_HOME:  col_pos = '0;
                K_END:   col_pos = col_lim;
                K_PGUP:  row_pos = '0;
                K_PGDN:  row_pos = row_lim;
                default: ;
            endcase
            key.key_kind = kind;
            key.key_char = ch;
            key.cursor_col = col_pos;
            key.cursor_row = row_pos;
            key.quit = (kind == K_PLAIN && ch == QUIT_BYTE);
        end
    endtask

    always @(posedge i_clk) begin
        logic      has_key;
        t_out_word key;
        t_out_word want;
        if (!i_rst_n) begin
            phase = PH_IDLE;
            seq_byte = '0;
            digit_byte = '0;
            col_pos = '0;
            row_pos = '0;
            rows_cfg = ROWS_RESET;
            cols_cfg = COLS_RESET;
            expected_keys.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SCREEN_ROWS) begin
                    rows_cfg = i_cfg_data;
                end else begin
                    cols_cfg = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_keys.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected result word: kind %0d char %02h col %0d row %0d quit %0b",
                                 i_out_word.key_kind, i_out_word.key_char,
                                 i_out_word.cursor_col, i_out_word.cursor_row, i_out_word.quit);
                    end
                end else begin
                    want = expected_keys.pop_front();
                    if (i_out_word !== want) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch at %0t: kind %0d/%0d char %02h/%02h col %0d/%0d row %0d/%0d quit %0b/%0b (expected/actual)",
                                     $realtime, want.key_kind, i_out_word.key_kind,
                                     want.key_char, i_out_word.key_char,
                                     want.cursor_col, i_out_word.cursor_col,
                                     want.cursor_row, i_out_word.cursor_row,
                                     want.quit, i_out_word.quit);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_key(i_in_word, has_key, key);
                if (has_key) begin
                    expected_keys.push_back(key);
                end
            end
        end
        o_pending <= expected_keys.size();
    end

endmodule

FILE: verif/escape_key_decoder_with_cursor_core_test.sv
// Stimulus and verdict for the escape key decoder with screen cursor.
`timescale 1ns / 1ps
module escape_key_decoder_with_cursor_core_test;
    import ekd_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in_word           in_word = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_word          out_word;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic               cfg_idx = REG_SCREEN_ROWS;
    logic [COORD_W-1:0] cfg_data = '0;
    int                 fail_count;
    int                 pending;

    int                 send_idle_pct = 26;
    int                 recv_idle_pct = 78;
    int                 hold_left = 0;
    int                 words_sent = 0;

    escape_key_decoder_with_cursor_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .i_word     (in_word),
        .o_stall    (in_stall),
        .o_valid    (out_valid),
        .o_word     (out_word),
        .i_stall    (out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    escape_key_decoder_with_cursor_checker key_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // Result side: a long hold has priority over the random stall.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        #1000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{action: act, rx_byte: b};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_escape(input string tail);
        send_word(ACT_BYTE, BYTE_ESC);
        foreach (tail[i]) send_word(ACT_BYTE, tail[i]);
    endtask

    task automatic stop_sending;
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every expected word has come, then lets the pipeline empty.
    task automatic drain;
        stop_sending();
        while (pending != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Traffic settings change at a rising edge so the result side never races them.
    task automatic set_traffic(input int send_pct, input int recv_pct, input int hold);
        stop_sending();
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        hold_left = hold;
        @(negedge clk);
    endtask

    task automatic write_screen(input logic [COORD_W-1:0] rows, input logic [COORD_W-1:0] cols);
        cfg_we <= 1'b1;
        cfg_idx <= REG_SCREEN_ROWS;
        cfg_data <= rows;
        @(negedge clk);
        cfg_idx <= REG_SCREEN_COLS;
        cfg_data <= cols;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Plain bytes, ticks, complete key sequences with random content, and
    // sequences that break off or go wrong.
    task automatic send_random_key;
        string      arrows = "ABCDHF";
        int         pick;
        logic [7:0] digit;
        pick = $urandom_range(99);
        digit = BYTE_ZERO + 8'($urandom_range(9));
        if (pick < 30) begin
            send_word(ACT_BYTE, 8'($urandom_range(255)));
        end else if (pick < 40) begin
            send_word(ACT_TICK, 8'($urandom_range(255)));
        end else if (pick < 75) begin
            send_word(ACT_BYTE, BYTE_ESC);
            case ($urandom_range(2))
                0: begin
                    send_word(ACT_BYTE, BYTE_BRACKET);
                    send_word(ACT_BYTE, arrows[$urandom_range(5)]);
                end
                1: begin
                    send_word(ACT_BYTE, BYTE_SS3);
                    send_word(ACT_BYTE, $urandom_range(1) ? BYTE_H : BYTE_F);
                end
                default: begin
                    send_word(ACT_BYTE, BYTE_BRACKET);
                    send_word(ACT_BYTE, digit);
                    send_word(ACT_BYTE, BYTE_TILDE);
                end
            endcase
        end else begin
            send_word(ACT_BYTE, BYTE_ESC);
            case ($urandom_range(3))
                0: begin
                    send_word(ACT_BYTE, 8'($urandom_range(255)));
                    send_word(ACT_BYTE, 8'($urandom_range(255)));
                end
                1: begin
                    send_word(ACT_BYTE, $urandom_range(1) ? BYTE_BRACKET : BYTE_SS3);
                    send_word(ACT_BYTE, 8'($urandom_range(255)));
                end
                2: begin
                    send_word(ACT_BYTE, BYTE_BRACKET);
                    send_word(ACT_BYTE, digit);
                    send_word(ACT_BYTE, 8'($urandom_range(255)));
                end
                default: begin
                    if ($urandom_range(1)) send_word(ACT_BYTE, BYTE_BRACKET);
                    if ($urandom_range(1)) send_word(ACT_BYTE, digit);
                    send_word(ACT_TICK, 8'($urandom_range(255)));
                end
            endcase
        end
    endtask

    task automatic send_random_block(input int count);
        int stop_at;
        stop_at = words_sent + count;
        while (words_sent < stop_at) send_random_key();
    endtask

    initial begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed keys on the reset screen, starting at the top left corner.
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, QUIT_BYTE);
        send_word(ACT_TICK, 8'hFF);
        send_escape("[A");
        send_escape("[D");
        send_escape("[B");
        send_escape("[C");
        send_escape("[F");
        send_escape("[H");
        send_escape("OF");
        send_escape("OH");
        send_escape("[1~");
        send_escape("[3~");
        send_escape("[4~");
        send_escape("[5~");
        send_escape("[6~");
        send_escape("[7~");
        send_escape("[8~");
        send_escape("[2~");
        send_escape("[5x");
        send_escape("[Z");
        send_escape("OA");
        send_escape("");
        send_word(ACT_TICK, 8'h00);
        send_escape("[");
        send_word(ACT_TICK, 8'h00);
        send_escape("[5");
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_BYTE, BYTE_ESC);
        send_escape("\033");

        drain();
        write_screen(12'd1, 12'd1);
        send_random_block(100);

        // Push the cursor to the far corner so the following shrink leaves it outside.
        drain();
        write_screen(12'd4095, 12'd4095);
        send_random_block(120);
        send_escape("[F");
        send_escape("[6~");

        drain();
        write_screen(12'd3, 12'd5);
        set_traffic(78, 26, 0);
        send_random_block(150);

        drain();
        write_screen(12'd0, 12'd0);
        send_random_block(100);

        // The result side holds off while words keep coming, so the key queue fills.
        drain();
        write_screen(12'($urandom_range(1, 40)), 12'($urandom_range(1, 100)));
        set_traffic(0, 0, 60);
        send_random_block(160);

        drain();
        write_screen(ROWS_RESET, COLS_RESET);
        set_traffic(0, 0, 40);
        send_random_block(120);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
